// ===== design/uer_pkg.sv =====
// Shared types and constants for the ultrasonic echo ranger.
// Used by uer_core and the ultrasonic_echo_ranger top level; no dependencies.
package uer_pkg;

  // Field and counter widths
  localparam int TIMEOUT_W = 16;
  localparam int TRIGGER_W = 8;
  localparam int COUNT_W   = 16;
  localparam int DIST_W    = 11;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;

  // Echo ticks per centimeter, and the remainder counter width
  localparam int CM_DIVISOR = 58;
  localparam int REM_W      = $clog2(CM_DIVISOR);

  // Register reset values
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(23200);
  localparam logic [TRIGGER_W-1:0] TRIGGER_RESET = TRIGGER_W'(10);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER = CFG_IDX_W'(1);

  // Measurement phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_TRIG = 4'b0010,
    PH_RISE = 4'b0100,
    PH_MEAS = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [TIMEOUT_W-1:0] timeout_ticks;
    logic [TRIGGER_W-1:0] trigger_ticks;
  } cfg_t;

  typedef struct packed {
    logic start_request;
    logic echo_level;
  } in_item_t;

  typedef struct packed {
    logic              trigger_out;
    logic              busy_res;
    logic              done_res;
    logic              ok;
    logic [DIST_W-1:0] distance_cm;
  } out_item_t;

endpackage

// ===== design/uer_core.sv =====
// Ranging state machine: one tick per accepted item, result formed combinationally.
// Depends on uer_pkg. Distance is kept as a running quotient/remainder by 58.
module uer_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  uer_pkg::in_item_t   item,
  input  uer_pkg::cfg_t       cfg,
  output uer_pkg::out_item_t  res
);

  localparam logic [uer_pkg::COUNT_W-1:0] CNT_MAX = '1;
  localparam logic [uer_pkg::REM_W-1:0]   REM_TOP = uer_pkg::REM_W'(uer_pkg::CM_DIVISOR - 1);

  uer_pkg::phase_t                   phase, phase_next;
  logic [uer_pkg::TRIGGER_W-1:0]     trigger_count, trigger_count_next;
  logic [uer_pkg::COUNT_W-1:0]       wait_count, wait_count_next;
  logic [uer_pkg::COUNT_W-1:0]       width_count, width_count_next;
  logic [uer_pkg::DIST_W-1:0]        width_quo, width_quo_next;
  logic [uer_pkg::REM_W-1:0]         width_rem, width_rem_next;
  logic                              echo_prev;
  logic [uer_pkg::DIST_W-1:0]        distance_hold, distance_hold_next;

  logic [uer_pkg::TRIGGER_W-1:0]     tlen;
  logic [uer_pkg::COUNT_W-1:0]       wait_base;
  logic                              waiting;
  logic                              done;
  logic                              good;

  // A trigger length of zero behaves as one tick
  assign tlen = (cfg.trigger_ticks == '0) ? uer_pkg::TRIGGER_W'(1) : cfg.trigger_ticks;

  // Next state for one tick
  always_comb begin
    phase_next         = phase;
    trigger_count_next = trigger_count;
    wait_count_next    = wait_count;
    width_count_next   = width_count;
    width_quo_next     = width_quo;
    width_rem_next     = width_rem;
    distance_hold_next = distance_hold;
    waiting            = 1'b0;
    done               = 1'b0;
    good               = 1'b0;
    wait_base          = wait_count;

    case (phase)
      uer_pkg::PH_IDLE: begin
        if (item.start_request) begin
          phase_next         = uer_pkg::PH_TRIG;
          trigger_count_next = uer_pkg::TRIGGER_W'(1);
        end
      end
      uer_pkg::PH_TRIG: begin
        if (trigger_count < tlen) begin
          trigger_count_next = trigger_count + 1'b1;
        end else begin
          // trigger ends; this tick is already the first waiting tick
          phase_next       = uer_pkg::PH_RISE;
          wait_base        = '0;
          width_count_next = '0;
          waiting          = 1'b1;
        end
      end
      uer_pkg::PH_RISE, uer_pkg::PH_MEAS: begin
        waiting = 1'b1;
      end
      default: begin
        phase_next = uer_pkg::PH_IDLE;
      end
    endcase

    if (waiting) begin
      if (phase_next == uer_pkg::PH_RISE) begin
        // rising edge opens the width count, that tick counts as one
        if (item.echo_level && !echo_prev) begin
          phase_next       = uer_pkg::PH_MEAS;
          width_count_next = uer_pkg::COUNT_W'(1);
          width_quo_next   = '0;
          width_rem_next   = uer_pkg::REM_W'(1);
        end
      end else begin
        if (!item.echo_level) begin
          distance_hold_next = width_quo;
          done               = 1'b1;
          good               = 1'b1;
          phase_next         = uer_pkg::PH_IDLE;
        end else if (width_count != CNT_MAX) begin
          width_count_next = width_count + 1'b1;
          if (width_rem == REM_TOP) begin
            width_rem_next = '0;
            width_quo_next = width_quo + 1'b1;
          end else begin
            width_rem_next = width_rem + 1'b1;
          end
        end
      end
      wait_count_next = wait_base;
      if (!done) begin
        if (wait_base != CNT_MAX) begin
          wait_count_next = wait_base + 1'b1;
        end
        // a measured echo on the same tick takes precedence
        if (cfg.timeout_ticks != '0 && wait_count_next >= cfg.timeout_ticks) begin
          done       = 1'b1;
          good       = 1'b0;
          phase_next = uer_pkg::PH_IDLE;
        end
      end
    end
  end

  // Result of this tick
  always_comb begin
    res.trigger_out = (phase_next == uer_pkg::PH_TRIG);
    res.busy_res    = (phase_next != uer_pkg::PH_IDLE);
    res.done_res    = done;
    res.ok          = done && good;
    res.distance_cm = distance_hold_next;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= uer_pkg::PH_IDLE;
      trigger_count <= '0;
      wait_count    <= '0;
      width_count   <= '0;
      width_quo     <= '0;
      width_rem     <= '0;
      echo_prev     <= 1'b0;
      distance_hold <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      trigger_count <= trigger_count_next;
      wait_count    <= wait_count_next;
      width_count   <= width_count_next;
      width_quo     <= width_quo_next;
      width_rem     <= width_rem_next;
      echo_prev     <= item.echo_level;
      distance_hold <= distance_hold_next;
    end
  end

endmodule

// ===== design/ultrasonic_echo_ranger.sv =====
// Ultrasonic echo ranger: one input item per tick, one result item per input item.
// Results are registered; throughput 1 item per cycle while in_ready is high (skid register empty).
// An output register plus a skid register take one more item while a result waits.
// Synchronous active-high reset: idle phase, counters and distance zero,
// timeout_ticks 23200, trigger_ticks 10, no result pending.
// Depends on uer_pkg and uer_core.
module ultrasonic_echo_ranger (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  uer_pkg::in_item_t              in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output uer_pkg::out_item_t             out_item,
  input  logic                           cfg_we,
  input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [uer_pkg::CFG_DAT_W-1:0]  cfg_data
);

  uer_pkg::cfg_t       cfg;
  uer_pkg::out_item_t  res;
  uer_pkg::out_item_t  skid_item;
  logic                skid_valid;
  logic                fire;
  logic                pop;

  assign in_ready = !skid_valid;
  assign fire     = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ticks <= uer_pkg::TIMEOUT_RESET;
      cfg.trigger_ticks <= uer_pkg::TRIGGER_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        uer_pkg::CFG_TIMEOUT: cfg.timeout_ticks <= cfg_data[uer_pkg::TIMEOUT_W-1:0];
        uer_pkg::CFG_TRIGGER: cfg.trigger_ticks <= cfg_data[uer_pkg::TRIGGER_W-1:0];
        default: ;
      endcase
    end
  end

  uer_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (in_item),
    .cfg  (cfg),
    .res  (res)
  );

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (fire) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Payload moves without reset
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_item <= skid_item;
      end
    end else if (fire) begin
      if (!out_valid || pop) begin
        out_item <= res;
      end else begin
        skid_item <= res;
      end
    end
  end

`ifndef SYNTHESIS
  // skid only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid item without output item");

  // an item entering a full skid stage would be lost
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !pop |=> skid_valid && $stable(skid_item))
    else $error("skid item lost or changed before output drained");

  // a finished measurement is never still busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    fire && res.done_res |-> !res.busy_res && !res.trigger_out)
    else $error("done reported while busy");

  // trigger is only driven during a measurement, ok only with done
  a_flags_consistent: assert property (@(posedge clk) disable iff (rst)
    fire |-> (!res.trigger_out || res.busy_res) && (!res.ok || res.done_res))
    else $error("inconsistent result flags");
`endif

endmodule
